@@ hdl/qrs_pkg.sv @@
`timescale 1ns / 1ps
package qrs_pkg;

	localparam int COEF_WIDTH = 16;
	localparam int FRAC_BITS = 16;
	localparam int VAL_WIDTH = 48;

	// Products and the discriminant.
	localparam int PROD_W = 2 * COEF_WIDTH;
	localparam int DISC_W = 2 * COEF_WIDTH + 3;
	localparam int DMAG_W = 2 * COEF_WIDTH + 2;

	// Square root of |D| scaled by 2^(2F).
	localparam int RAD_W = DMAG_W + 2 * FRAC_BITS;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W = ROOT_W + 2;

	// Division operands.
	localparam int NB_W = COEF_WIDTH + FRAC_BITS + 1;
	localparam int DEN_W = COEF_WIDTH + 2;
	localparam int DENM_W = COEF_WIDTH + 1;
	localparam int NUM_W = ROOT_W + 2;
	localparam int LANES = 2;

	typedef enum logic [1:0] {
		KIND_DISTINCT = 2'd0,
		KIND_REPEATED = 2'd1,
		KIND_COMPLEX  = 2'd2,
		KIND_INVALID  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [NB_W-1:0]   nb;
		logic signed [DEN_W-1:0]  den;
	} tag_t;

	typedef struct packed {
		kind_t            kind;
		logic [LANES-1:0] neg;
	} div_tag_t;

endpackage

@@ hdl/qrs_in_if.sv @@
`timescale 1ns / 1ps
interface qrs_in_if;
	logic valid;
	logic ready;
	logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_a;
	logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_b;
	logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_c;

	modport source(output valid, output coef_a, output coef_b, output coef_c, input ready);
	modport sink(input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

@@ hdl/qrs_out_if.sv @@
`timescale 1ns / 1ps
interface qrs_out_if;
	logic valid;
	logic ready;
	logic [1:0] root_kind;
	logic signed [qrs_pkg::VAL_WIDTH-1:0] first_value;
	logic signed [qrs_pkg::VAL_WIDTH-1:0] second_value;

	modport source(output valid, output root_kind, output first_value, output second_value,
		input ready);
	modport sink(input valid, input root_kind, input first_value, input second_value,
		output ready);
endinterface

@@ hdl/qrs_sqrt.sv @@
`timescale 1ns / 1ps
module qrs_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        rad_valid,
	input  logic [qrs_pkg::RAD_W-1:0]   rad,
	input  qrs_pkg::tag_t               tag,
	output logic                        root_valid,
	output logic [qrs_pkg::ROOT_W-1:0]  root,
	output qrs_pkg::tag_t               root_tag
);
	import qrs_pkg::*;

	// One result bit per stage, two radicand bits brought in per stage.
	logic              v_s    [0:ROOT_W];
	logic [RAD_W-1:0]  rad_s  [0:ROOT_W];
	logic [REM_W-1:0]  rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	tag_t              tag_s  [0:ROOT_W];

	assign v_s[0]    = rad_valid;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign tag_s[0]  = tag;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             ge;

		assign rem_sh = {rem_s[i][REM_W-3:0], rad_s[i][RAD_W-1 -: 2]};
		assign trial  = {root_s[i], 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i+1]  <= rad_s[i] << 2;
				rem_s[i+1]  <= ge ? rem_sh - trial : rem_sh;
				root_s[i+1] <= {root_s[i][ROOT_W-2:0], ge};
				tag_s[i+1]  <= tag_s[i];
			end
		end
	end

	assign root_valid = v_s[ROOT_W];
	assign root       = root_s[ROOT_W];
	assign root_tag   = tag_s[ROOT_W];
endmodule

@@ hdl/qrs_div.sv @@
`timescale 1ns / 1ps
module qrs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        num_valid,
	input  logic [qrs_pkg::NUM_W-1:0]   num_mag [qrs_pkg::LANES],
	input  logic [qrs_pkg::DENM_W-1:0]  den_mag,
	input  qrs_pkg::div_tag_t           tag,
	output logic                        quot_valid,
	output logic [qrs_pkg::NUM_W-1:0]   quot [qrs_pkg::LANES],
	output qrs_pkg::div_tag_t           quot_tag
);
	import qrs_pkg::*;

	// Restoring division, one quotient bit per stage; both lanes share the divisor.
	logic              v_s   [0:NUM_W];
	logic [NUM_W-1:0]  num_s [0:NUM_W][LANES];
	logic [DENM_W-1:0] rem_s [0:NUM_W][LANES];
	logic [DENM_W-1:0] den_s [0:NUM_W];
	div_tag_t          tag_s [0:NUM_W];

	assign v_s[0]   = num_valid;
	assign den_s[0] = den_mag;
	assign tag_s[0] = tag;
	for (genvar l = 0; l < LANES; l++) begin : g_in
		assign num_s[0][l] = num_mag[l];
		assign rem_s[0][l] = '0;
	end

	for (genvar i = 0; i < NUM_W; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1] <= den_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DENM_W:0] sh;
			logic            ge;
			logic [DENM_W:0] diff;

			assign sh   = {rem_s[i][l], num_s[i][l][NUM_W-1]};
			assign ge   = (sh >= {1'b0, den_s[i]});
			assign diff = sh - {1'b0, den_s[i]};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1][l] <= ge ? diff[DENM_W-1:0] : sh[DENM_W-1:0];
					num_s[i+1][l] <= {num_s[i][l][NUM_W-2:0], ge};
				end
			end
		end
	end

	assign quot_valid = v_s[NUM_W];
	assign quot_tag   = tag_s[NUM_W];
	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign quot[l] = num_s[NUM_W][l];
	end
endmodule

@@ hdl/quadratic_root_solver_top.sv @@
`timescale 1ns / 1ps
// Stages from an accepted beat to its result: 2 product and discriminant stages,
// 33 square root stages, 1 operand stage and 35 divider stages.
// Throughput: one equation per cycle; the whole pipeline holds when the result is not taken.
// Reset: arst_n clears all stage valid bits asynchronously; data registers are not reset.
module quadratic_root_solver_top (
	input  logic       clk,
	input  logic       arst_n,
	qrs_in_if.sink     coef_ch,
	qrs_out_if.source  root_ch
);
	import qrs_pkg::*;

	logic en;
	assign en            = !root_ch.valid || root_ch.ready;
	assign coef_ch.ready = en;

	// Stage 1: products.
	logic                          v_s1;
	logic signed [PROD_W-1:0]      bb_s1;
	logic signed [PROD_W-1:0]      ac_s1;
	logic signed [COEF_WIDTH-1:0]  a_s1;
	logic signed [COEF_WIDTH-1:0]  b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= coef_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1 <= coef_ch.coef_b * coef_ch.coef_b;
			ac_s1 <= coef_ch.coef_a * coef_ch.coef_c;
			a_s1  <= coef_ch.coef_a;
			b_s1  <= coef_ch.coef_b;
		end
	end

	// Stage 2: discriminant, classification and scaled radicand.
	logic signed [DISC_W-1:0] disc;
	logic [DISC_W-1:0]        disc_abs;
	kind_t                    kind_c;
	logic                     v_s2;
	logic [RAD_W-1:0]         rad_s2;
	tag_t                     tag_s2;

	assign disc     = DISC_W'(bb_s1) - (DISC_W'(ac_s1) <<< 2);
	assign disc_abs = disc[DISC_W-1] ? -disc : disc;

	always_comb begin
		if (a_s1 == '0) begin
			kind_c = KIND_INVALID;
		end else if (disc[DISC_W-1]) begin
			kind_c = KIND_COMPLEX;
		end else if (disc == '0) begin
			kind_c = KIND_REPEATED;
		end else begin
			kind_c = KIND_DISTINCT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2      <= {disc_abs[DMAG_W-1:0], {(2 * FRAC_BITS){1'b0}}};
			tag_s2.kind <= kind_c;
			tag_s2.nb   <= (-(NB_W'(b_s1))) <<< FRAC_BITS;
			tag_s2.den  <= DEN_W'(a_s1) <<< 1;
		end
	end

	// Square root pipeline.
	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root;
	tag_t              sq_tag;

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.rad_valid (v_s2),
		.rad       (rad_s2),
		.tag       (tag_s2),
		.root_valid(sq_valid),
		.root      (sq_root),
		.root_tag  (sq_tag)
	);

	// Stage 3: signed numerators reduced to magnitudes and quotient signs.
	logic signed [NUM_W:0] n1;
	logic signed [NUM_W:0] n2;
	logic                  neg1;
	logic                  neg2;
	logic                  den_neg;
	logic [DEN_W-1:0]      den_abs;
	logic                  v_s3;
	logic [NUM_W-1:0]      num_s3 [LANES];
	logic [DENM_W-1:0]     den_s3;
	div_tag_t              dtag_s3;

	assign den_neg = sq_tag.den[DEN_W-1];
	assign den_abs = den_neg ? -sq_tag.den : sq_tag.den;

	always_comb begin
		logic signed [NUM_W:0] nbx;
		logic signed [NUM_W:0] sx;
		nbx = (NUM_W + 1)'(sq_tag.nb);
		sx  = (NUM_W + 1)'(sq_root);
		n1   = '0;
		n2   = '0;
		neg1 = 1'b0;
		neg2 = 1'b0;
		case (sq_tag.kind)
			KIND_DISTINCT: begin
				n1   = nbx + sx;
				n2   = nbx - sx;
				neg1 = n1[NUM_W] ^ den_neg;
				neg2 = n2[NUM_W] ^ den_neg;
			end
			KIND_REPEATED: begin
				n1   = nbx;
				n2   = nbx;
				neg1 = nbx[NUM_W] ^ den_neg;
				neg2 = nbx[NUM_W] ^ den_neg;
			end
			KIND_COMPLEX: begin
				// The imaginary part divides by |2a| and stays positive.
				n1   = nbx;
				n2   = sx;
				neg1 = nbx[NUM_W] ^ den_neg;
				neg2 = 1'b0;
			end
			default: begin
				n1 = '0;
				n2 = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3[0]    <= n1[NUM_W] ? NUM_W'(-n1) : NUM_W'(n1);
			num_s3[1]    <= n2[NUM_W] ? NUM_W'(-n2) : NUM_W'(n2);
			// An invalid item divides zero by one so that both values come out zero.
			den_s3       <= (sq_tag.kind == KIND_INVALID) ? DENM_W'(1) : den_abs[DENM_W-1:0];
			dtag_s3.kind <= sq_tag.kind;
			dtag_s3.neg  <= {neg2, neg1};
		end
	end

	// Divider pipeline; its last stage is the output register.
	logic             dv_valid;
	logic [NUM_W-1:0] dv_quot [LANES];
	div_tag_t         dv_tag;

	qrs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.num_valid (v_s3),
		.num_mag   (num_s3),
		.den_mag   (den_s3),
		.tag       (dtag_s3),
		.quot_valid(dv_valid),
		.quot      (dv_quot),
		.quot_tag  (dv_tag)
	);

	logic signed [VAL_WIDTH-1:0] q1;
	logic signed [VAL_WIDTH-1:0] q2;
	assign q1 = VAL_WIDTH'(dv_quot[0]);
	assign q2 = VAL_WIDTH'(dv_quot[1]);

	assign root_ch.valid        = dv_valid;
	assign root_ch.root_kind    = dv_tag.kind;
	assign root_ch.first_value  = dv_tag.neg[0] ? -q1 : q1;
	assign root_ch.second_value = dv_tag.neg[1] ? -q2 : q2;
endmodule

@@ sim/tb_quadratic_root_solver_top.sv @@
`timescale 1ns / 1ps
module tb_quadratic_root_solver_top;
	import qrs_pkg::*;

	localparam int RANDOM_EQS = 1430;
	localparam int PIPE_LAT = 71;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [COEF_WIDTH-1:0] a;
		logic signed [COEF_WIDTH-1:0] b;
		logic signed [COEF_WIDTH-1:0] c;
	} coefs_t;

	typedef struct {
		kind_t                       kind;
		logic signed [VAL_WIDTH-1:0] first;
		logic signed [VAL_WIDTH-1:0] second;
	} roots_t;

	typedef struct {
		coefs_t eq;
		bit     typed;
		roots_t known;
	} eq_row_t;

	logic clk;
	logic arst_n;
	qrs_in_if  coef_ch();
	qrs_out_if root_ch();

	quadratic_root_solver_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.coef_ch(coef_ch),
		.root_ch(root_ch)
	);

	roots_t pending_roots[$];
	int mismatches = 0;
	int eqs_sent = 0;
	int roots_seen = 0;
	int kind_hits[4] = '{0, 0, 0, 0};
	longint cycles = 0;
	bit stim_done = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	function automatic logic signed [VAL_WIDTH-1:0] clamp_q(input longint v);
		longint hi;
		hi = (longint'(1) <<< (VAL_WIDTH - 1)) - 1;
		if (v > hi)
			v = hi;
		if (v < -hi - 1)
			v = -hi - 1;
		return v[VAL_WIDTH-1:0];
	endfunction

	// Roots in signed fixed point; the discriminant is exact in 64 bits for 16-bit coefficients.
	function automatic roots_t solve_roots(input coefs_t eq);
		roots_t r;
		longint a, b, c, disc, den, nb, sroot;
		logic [127:0] rad, trial;
		a = eq.a;
		b = eq.b;
		c = eq.c;
		if (a == 0) begin
			r.kind = KIND_INVALID;
			r.first = '0;
			r.second = '0;
			return r;
		end
		disc = b * b - 4 * a * c;
		rad = 128'(disc < 0 ? -disc : disc) << (2 * FRAC_BITS);
		sroot = 0;
		for (int i = 62; i >= 0; i--) begin
			trial = 128'(sroot | (longint'(1) <<< i));
			if (trial * trial <= rad)
				sroot = longint'(trial);
		end
		den = 2 * a;
		nb = -b * (longint'(1) <<< FRAC_BITS);
		if (disc < 0) begin
			r.kind = KIND_COMPLEX;
			r.first = clamp_q(nb / den);
			r.second = clamp_q(sroot / (den < 0 ? -den : den));
		end else if (disc == 0) begin
			r.kind = KIND_REPEATED;
			r.first = clamp_q(nb / den);
			r.second = r.first;
		end else begin
			r.kind = KIND_DISTINCT;
			r.first = clamp_q((nb + sroot) / den);
			r.second = clamp_q((nb - sroot) / den);
		end
		return r;
	endfunction

	function automatic int draw_wait(input int n);
		// Every third block of 150 beats runs without any idle cycles.
		if ((n / 150) % 3 == 2)
			return 0;
		return $urandom_range(0, 4);
	endfunction

	function automatic logic signed [COEF_WIDTH-1:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2, 3: return COEF_WIDTH'(int'($urandom_range(0, 16)) - 8);
			default: return COEF_WIDTH'($urandom);
		endcase
	endfunction

	function automatic coefs_t random_eq();
		coefs_t eq;
		int root, scale;
		case ($urandom_range(0, 9))
			0: begin
				// Repeated root: a*(x - r)^2 with small r and scale.
				root = $urandom_range(0, 40) - 20;
				scale = $urandom_range(1, 20) * ($urandom_range(0, 1) ? 1 : -1);
				eq.a = COEF_WIDTH'(scale);
				eq.b = COEF_WIDTH'(-2 * scale * root);
				eq.c = COEF_WIDTH'(scale * root * root);
			end
			1: begin
				eq.a = '0;
				eq.b = COEF_WIDTH'($urandom);
				eq.c = COEF_WIDTH'($urandom);
			end
			2, 3, 4: begin
				eq.a = rand_coef();
				eq.b = rand_coef();
				eq.c = rand_coef();
			end
			default: begin
				eq.a = COEF_WIDTH'($urandom);
				eq.b = COEF_WIDTH'($urandom);
				eq.c = COEF_WIDTH'($urandom);
			end
		endcase
		return eq;
	endfunction

	task automatic send_eq(input eq_row_t row);
		int gap;
		gap = draw_wait(eqs_sent);
		if (gap > 0) begin
			coef_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		coef_ch.valid <= 1'b1;
		coef_ch.coef_a <= row.eq.a;
		coef_ch.coef_b <= row.eq.b;
		coef_ch.coef_c <= row.eq.c;
		do
			@(posedge clk);
		while (!coef_ch.ready);
		pending_roots.push_back(row.typed ? row.known : solve_roots(row.eq));
		eqs_sent++;
		@(negedge clk);
	endtask

	eq_row_t directed[] = '{
		'{'{16'sd0, 16'sd5, 16'sd7}, 1, '{KIND_INVALID, 48'sd0, 48'sd0}},
		'{'{16'sd0, -16'sd32768, 16'sd32767}, 1, '{KIND_INVALID, 48'sd0, 48'sd0}},
		'{'{16'sd1, 16'sd0, 16'sd0}, 1, '{KIND_REPEATED, 48'sd0, 48'sd0}},
		'{'{16'sd1, -16'sd2, 16'sd1}, 1, '{KIND_REPEATED, 48'sd65536, 48'sd65536}},
		'{'{16'sd1, 16'sd0, -16'sd1}, 1, '{KIND_DISTINCT, 48'sd65536, -48'sd65536}},
		'{'{16'sd1, 16'sd0, 16'sd1}, 1, '{KIND_COMPLEX, 48'sd0, 48'sd65536}},
		'{'{-16'sd1, 16'sd0, 16'sd1}, 0, '{KIND_DISTINCT, 48'sd0, 48'sd0}},
		'{'{16'sd1, -16'sd3, 16'sd2}, 0, '{KIND_DISTINCT, 48'sd0, 48'sd0}},
		'{'{16'sd2, 16'sd3, 16'sd5}, 0, '{KIND_DISTINCT, 48'sd0, 48'sd0}},
		'{'{16'sd32767, 16'sd32767, 16'sd32767}, 0, '{KIND_DISTINCT, 48'sd0, 48'sd0}},
		'{'{-16'sd32768, -16'sd32768, -16'sd32768}, 0, '{KIND_DISTINCT, 48'sd0, 48'sd0}},
		'{'{-16'sd32768, -16'sd32768, 16'sd32767}, 0, '{KIND_DISTINCT, 48'sd0, 48'sd0}},
		'{'{16'sd32767, -16'sd32768, -16'sd32768}, 0, '{KIND_DISTINCT, 48'sd0, 48'sd0}},
		'{'{16'sd1, -16'sd32768, 16'sd0}, 0, '{KIND_DISTINCT, 48'sd0, 48'sd0}},
		'{'{16'sd1, 16'sd32767, -16'sd32768}, 0, '{KIND_DISTINCT, 48'sd0, 48'sd0}},
		'{'{-16'sd1, 16'sd0, -16'sd32768}, 0, '{KIND_DISTINCT, 48'sd0, 48'sd0}},
		'{'{16'sd1, 16'sd0, 16'sd32767}, 0, '{KIND_DISTINCT, 48'sd0, 48'sd0}},
		'{'{-16'sd32768, 16'sd0, 16'sd32767}, 0, '{KIND_DISTINCT, 48'sd0, 48'sd0}},
		'{'{-16'sd3, 16'sd12, -16'sd12}, 0, '{KIND_DISTINCT, 48'sd0, 48'sd0}},
		'{'{-16'sd1, 16'sd1, -16'sd1}, 0, '{KIND_DISTINCT, 48'sd0, 48'sd0}}
	};

	initial begin
		eq_row_t row;
		arst_n = 1'b0;
		coef_ch.valid = 1'b0;
		coef_ch.coef_a = '0;
		coef_ch.coef_b = '0;
		coef_ch.coef_c = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (directed[i])
			send_eq(directed[i]);
		for (int i = 0; i < RANDOM_EQS; i++) begin
			row.eq = random_eq();
			row.typed = 0;
			send_eq(row);
		end
		coef_ch.valid <= 1'b0;
		stim_done = 1;
	end

	// The receiver draws a stall before each result beat.
	initial begin
		int stall;
		root_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = draw_wait(roots_seen);
			if (stall > 0) begin
				root_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			root_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!root_ch.valid);
		end
	end

	always @(posedge clk) begin
		roots_t want;
		if (arst_n && root_ch.valid && root_ch.ready) begin
			roots_seen++;
			if (pending_roots.size() == 0) begin
				report($sformatf("unexpected result kind %0d", root_ch.root_kind));
			end else begin
				want = pending_roots.pop_front();
				kind_hits[want.kind]++;
				if (root_ch.root_kind !== want.kind)
					report($sformatf("root_kind %0d, expected %0d", root_ch.root_kind,
						want.kind));
				if (root_ch.first_value !== want.first)
					report($sformatf("first_value %0d, expected %0d",
						root_ch.first_value, want.first));
				if (root_ch.second_value !== want.second)
					report($sformatf("second_value %0d, expected %0d",
						root_ch.second_value, want.second));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_roots.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		while (pending_roots.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
		$display("%0d equations solved: %0d distinct, %0d repeated, %0d complex, %0d invalid",
			roots_seen, kind_hits[KIND_DISTINCT], kind_hits[KIND_REPEATED],
			kind_hits[KIND_COMPLEX], kind_hits[KIND_INVALID]);
		$display("random stalls on both sides, %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
